// ===== sv/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// drc_pkg
// shared types, opcodes and helpers for the diophantine range counter
// ----------------------------------------------------------------------------
package drc_pkg;

    localparam int DW              = 64;  // datapath word
    localparam int IN_W            = 32;  // coefficient port width
    localparam int XYW             = 31;  // range bound width
    localparam int CNTW            = 63;  // count width
    localparam int MW              = 32;  // multiplier operand magnitude width
    localparam int DEF_COEF_WIDTH  = 32;

    typedef logic signed [DW-1:0] word_t;
    typedef logic [4:0] op_t;

    localparam op_t OP_NONE     = 5'd0;
    localparam op_t OP_EG_INIT  = 5'd1;
    localparam op_t OP_EG_DIV   = 5'd2;
    localparam op_t OP_EG_MUL   = 5'd3;
    localparam op_t OP_EG_UPD   = 5'd4;
    localparam op_t OP_MUL_W    = 5'd5;
    localparam op_t OP_FIN_BOTH = 5'd6;
    localparam op_t OP_DIV_AZ   = 5'd7;
    localparam op_t OP_DIV_BZ   = 5'd8;
    localparam op_t OP_DIV_CG   = 5'd9;
    localparam op_t OP_DIV_AG   = 5'd10;
    localparam op_t OP_DIV_BG   = 5'd11;
    localparam op_t OP_MUL_X    = 5'd12;
    localparam op_t OP_NEG_X    = 5'd13;
    localparam op_t OP_DIV_X    = 5'd14;
    localparam op_t OP_MUL_Y    = 5'd15;
    localparam op_t OP_DIV_Y    = 5'd16;
    localparam op_t OP_DIV_T1L  = 5'd17;
    localparam op_t OP_DIV_T1H  = 5'd18;
    localparam op_t OP_DIV_T2L  = 5'd19;
    localparam op_t OP_DIV_T2H  = 5'd20;
    localparam op_t OP_FIN_GEN  = 5'd21;
    localparam op_t OP_ZERO     = 5'd22;

    typedef struct packed {
        op_t  op;
        logic load;
        logic div_start;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic r1_zero;
        logic div_done;
        logic rem_zero;
    } sts_t;

    function automatic word_t width_of(input word_t lo, input word_t hi);
        word_t w;
        begin
            w = '0;
            if (lo <= hi)
            begin
                w = hi - lo + word_t'(1);
            end
            return w;
        end
    endfunction

    function automatic word_t abs_w(input word_t v);
        return (v < 0) ? -v : v;
    endfunction

endpackage

// ===== sv/drc_div.sv =====
// ----------------------------------------------------------------------------
// drc_div
// signed restoring divider, one quotient bit per cycle, truncating result
// ----------------------------------------------------------------------------
module drc_div
    import drc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t num,
    input  word_t den,
    output logic  done,
    output word_t quo,
    output word_t rem
);

    localparam int CB = $clog2(DW);

    logic [DW-1:0] den_reg;
    logic [DW-1:0] n_reg;
    logic [DW-1:0] acc_reg;
    logic          neg_q_reg;
    logic          neg_r_reg;
    logic [CB-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] acc_next;
    logic [DW-1:0] n_next;

    always_comb
    begin
        sh       = {acc_reg, n_reg[DW-1]};
        diff     = sh - {1'b0, den_reg};
        ge       = (sh >= {1'b0, den_reg});
        acc_next = ge ? diff[DW-1:0] : sh[DW-1:0];
        n_next   = {n_reg[DW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CB'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg   <= abs_w(den);
            n_reg     <= abs_w(num);
            acc_reg   <= '0;
            neg_q_reg <= (num < 0) != (den < 0);
            neg_r_reg <= (num < 0);
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            n_reg   <= n_next;
        end
    end

    assign done = done_reg;
    assign quo  = neg_q_reg ? -word_t'(n_reg) : word_t'(n_reg);
    assign rem  = neg_r_reg ? -word_t'(acc_reg) : word_t'(acc_reg);

endmodule

// ===== sv/drc_dp.sv =====
// ----------------------------------------------------------------------------
// drc_dp
// datapath: operand registers, shared divider, 32x32 multiplier, count
// ----------------------------------------------------------------------------
module drc_dp
    import drc_pkg::*;
#(
    parameter int COEF_WIDTH = DEF_COEF_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic signed [IN_W-1:0] coef_a,
    input  logic signed [IN_W-1:0] coef_b,
    input  logic signed [IN_W-1:0] rhs_c,
    input  logic signed [XYW-1:0]  x_low,
    input  logic signed [XYW-1:0]  x_high,
    input  logic signed [XYW-1:0]  y_low,
    input  logic signed [XYW-1:0]  y_high,
    output logic [CNTW-1:0]        solution_count
);

    logic signed [COEF_WIDTH-1:0] a_tr, b_tr, c_tr;

    word_t a_reg, b_reg, c_reg, xl_reg, xh_reg, yl_reg, yh_reg;
    word_t r0_reg, r1_reg, s0_reg, s1_reg;
    word_t cr_reg, ar_reg, br_reg, x0_reg, y0_reg;
    word_t t1l_reg, t1h_reg, t2l_reg, t2h_reg;
    word_t mul_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] out_reg;

    word_t div_num, div_den, quo, rem;
    logic  div_done;
    word_t wx, wy, bm, am;
    word_t mop_a, mop_b, mul_next;
    logic [MW-1:0]   ua, ub;
    logic [2*MW-1:0] pm;
    word_t tl_w, th_w, span;
    logic  rem_pos, rem_neg;

    assign a_tr = coef_a[COEF_WIDTH-1:0];
    assign b_tr = coef_b[COEF_WIDTH-1:0];
    assign c_tr = rhs_c[COEF_WIDTH-1:0];

    assign wx = width_of(xl_reg, xh_reg);
    assign wy = width_of(yl_reg, yh_reg);
    assign bm = abs_w(br_reg);
    assign am = abs_w(ar_reg);
    assign rem_pos = (rem > 0);
    assign rem_neg = (rem < 0);

    drc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo),
        .rem   (rem)
    );

    // divider operand select
    always_comb
    begin
        div_num = r0_reg;
        div_den = r1_reg;
        case (cmd.op)
            OP_EG_DIV:  begin div_num = r0_reg; div_den = r1_reg; end
            OP_DIV_AZ:  begin div_num = c_reg;  div_den = b_reg;  end
            OP_DIV_BZ:  begin div_num = c_reg;  div_den = a_reg;  end
            OP_DIV_CG:  begin div_num = c_reg;  div_den = r0_reg; end
            OP_DIV_AG:  begin div_num = a_reg;  div_den = r0_reg; end
            OP_DIV_BG:  begin div_num = b_reg;  div_den = r0_reg; end
            OP_DIV_X:   begin div_num = x0_reg; div_den = bm;     end
            OP_DIV_Y:   begin div_num = cr_reg - mul_reg; div_den = br_reg; end
            OP_DIV_T1L:
            begin
                div_num = (br_reg < 0) ? x0_reg - xh_reg : xl_reg - x0_reg;
                div_den = bm;
            end
            OP_DIV_T1H:
            begin
                div_num = (br_reg < 0) ? x0_reg - xl_reg : xh_reg - x0_reg;
                div_den = bm;
            end
            OP_DIV_T2L:
            begin
                div_num = (ar_reg < 0) ? yl_reg - y0_reg : y0_reg - yh_reg;
                div_den = am;
            end
            OP_DIV_T2H:
            begin
                div_num = (ar_reg < 0) ? yh_reg - y0_reg : y0_reg - yl_reg;
                div_den = am;
            end
            default: ;
        endcase
    end

    // multiplier operands, all magnitudes fit in 32 bits
    always_comb
    begin
        mop_a = quo;
        mop_b = s1_reg;
        case (cmd.op)
            OP_EG_MUL: begin mop_a = quo;    mop_b = s1_reg; end
            OP_MUL_W:  begin mop_a = wx;     mop_b = wy;     end
            OP_MUL_X:  begin mop_a = s0_reg; mop_b = cr_reg; end
            OP_MUL_Y:  begin mop_a = ar_reg; mop_b = x0_reg; end
            default: ;
        endcase
        ua = MW'(abs_w(mop_a));
        ub = MW'(abs_w(mop_b));
        pm = ua * ub;
        mul_next = ((mop_a < 0) != (mop_b < 0)) ? -word_t'(pm) : word_t'(pm);
    end

    always_comb
    begin
        tl_w = (t1l_reg > t2l_reg) ? t1l_reg : t2l_reg;
        th_w = (t1h_reg < t2h_reg) ? t1h_reg : t2h_reg;
        span = th_w - tl_w + word_t'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg  <= word_t'(a_tr);
            b_reg  <= word_t'(b_tr);
            c_reg  <= word_t'(c_tr);
            xl_reg <= word_t'(x_low);
            xh_reg <= word_t'(x_high);
            yl_reg <= word_t'(y_low);
            yh_reg <= word_t'(y_high);
        end
        if (cmd.push)
        begin
            out_reg <= cnt_reg;
        end
        case (cmd.op)
            OP_EG_INIT:
            begin
                r0_reg <= abs_w(a_reg);
                r1_reg <= abs_w(b_reg);
                s0_reg <= word_t'(1);
                s1_reg <= '0;
            end
            OP_EG_MUL, OP_MUL_W, OP_MUL_X, OP_MUL_Y:
            begin
                mul_reg <= mul_next;
            end
            OP_EG_UPD:
            begin
                r0_reg <= r1_reg;
                r1_reg <= rem;
                s0_reg <= s1_reg;
                s1_reg <= s0_reg - mul_reg;
            end
            OP_FIN_BOTH:
            begin
                cnt_reg <= (c_reg == 0) ? mul_reg[CNTW-1:0] : '0;
            end
            OP_NEG_X:
            begin
                x0_reg <= (a_reg < 0) ? -mul_reg : mul_reg;
            end
            OP_FIN_GEN:
            begin
                cnt_reg <= (tl_w <= th_w) ? span[CNTW-1:0] : '0;
            end
            OP_ZERO:
            begin
                cnt_reg <= '0;
            end
            default: ;
        endcase
        if (div_done)
        begin
            case (cmd.op)
                OP_DIV_AZ:
                begin
                    cnt_reg <= (rem == 0 && quo >= yl_reg && quo <= yh_reg)
                               ? wx[CNTW-1:0] : '0;
                end
                OP_DIV_BZ:
                begin
                    cnt_reg <= (rem == 0 && quo >= xl_reg && quo <= xh_reg)
                               ? wy[CNTW-1:0] : '0;
                end
                OP_DIV_CG:  cr_reg  <= quo;
                OP_DIV_AG:  ar_reg  <= quo;
                OP_DIV_BG:  br_reg  <= quo;
                OP_DIV_X:   x0_reg  <= rem_neg ? rem + bm : rem;
                OP_DIV_Y:   y0_reg  <= quo;
                // ceil for lower bounds, floor for upper bounds
                OP_DIV_T1L: t1l_reg <= quo + word_t'(rem_pos);
                OP_DIV_T1H: t1h_reg <= quo - word_t'(rem_neg);
                OP_DIV_T2L: t2l_reg <= quo + word_t'(rem_pos);
                OP_DIV_T2H: t2h_reg <= quo - word_t'(rem_neg);
                default: ;
            endcase
        end
    end

    assign sts.a_zero   = (a_reg == 0);
    assign sts.b_zero   = (b_reg == 0);
    assign sts.r1_zero  = (r1_reg == 0);
    assign sts.div_done = div_done;
    assign sts.rem_zero = (rem == 0);

    assign solution_count = out_reg;

endmodule

// ===== sv/drc_ctrl.sv =====
// ----------------------------------------------------------------------------
// drc_ctrl
// sequencer: steps the datapath through euclid, reduction and range bounds
// ----------------------------------------------------------------------------
module drc_ctrl
    import drc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISPATCH = 5'd1;
    localparam logic [4:0] S_EG_INIT  = 5'd2;
    localparam logic [4:0] S_EG_CHK   = 5'd3;
    localparam logic [4:0] S_EG_DIV   = 5'd4;
    localparam logic [4:0] S_EG_MUL   = 5'd5;
    localparam logic [4:0] S_EG_UPD   = 5'd6;
    localparam logic [4:0] S_MUL_W    = 5'd7;
    localparam logic [4:0] S_FIN_BOTH = 5'd8;
    localparam logic [4:0] S_DIV_AZ   = 5'd9;
    localparam logic [4:0] S_DIV_BZ   = 5'd10;
    localparam logic [4:0] S_DIV_CG   = 5'd11;
    localparam logic [4:0] S_DIV_AG   = 5'd12;
    localparam logic [4:0] S_DIV_BG   = 5'd13;
    localparam logic [4:0] S_MUL_X    = 5'd14;
    localparam logic [4:0] S_NEG_X    = 5'd15;
    localparam logic [4:0] S_DIV_X    = 5'd16;
    localparam logic [4:0] S_MUL_Y    = 5'd17;
    localparam logic [4:0] S_DIV_Y    = 5'd18;
    localparam logic [4:0] S_T1L      = 5'd19;
    localparam logic [4:0] S_T1H      = 5'd20;
    localparam logic [4:0] S_T2L      = 5'd21;
    localparam logic [4:0] S_T2H      = 5'd22;
    localparam logic [4:0] S_FIN_GEN  = 5'd23;
    localparam logic [4:0] S_ZERO     = 5'd24;
    localparam logic [4:0] S_OUT      = 5'd25;

    logic [4:0] state_reg, state_next;
    logic       started_reg, started_next;
    logic       out_valid_reg, out_valid_next;
    logic       is_div;

    always_comb
    begin
        cmd            = '0;
        cmd.op         = OP_NONE;
        state_next     = state_reg;
        is_div         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.a_zero && sts.b_zero)
                begin
                    state_next = S_MUL_W;
                end
                else if (sts.a_zero)
                begin
                    state_next = S_DIV_AZ;
                end
                else if (sts.b_zero)
                begin
                    state_next = S_DIV_BZ;
                end
                else
                begin
                    state_next = S_EG_INIT;
                end
            end
            S_EG_INIT:
            begin
                cmd.op = OP_EG_INIT;
                state_next = S_EG_CHK;
            end
            S_EG_CHK:
            begin
                state_next = sts.r1_zero ? S_DIV_CG : S_EG_DIV;
            end
            S_EG_DIV:
            begin
                cmd.op = OP_EG_DIV;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_EG_MUL;
                end
            end
            S_EG_MUL:
            begin
                cmd.op = OP_EG_MUL;
                state_next = S_EG_UPD;
            end
            S_EG_UPD:
            begin
                cmd.op = OP_EG_UPD;
                state_next = S_EG_CHK;
            end
            S_MUL_W:
            begin
                cmd.op = OP_MUL_W;
                state_next = S_FIN_BOTH;
            end
            S_FIN_BOTH:
            begin
                cmd.op = OP_FIN_BOTH;
                state_next = S_OUT;
            end
            S_DIV_AZ:
            begin
                cmd.op = OP_DIV_AZ;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV_BZ:
            begin
                cmd.op = OP_DIV_BZ;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV_CG:
            begin
                cmd.op = OP_DIV_CG;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    // gcd must divide c
                    state_next = sts.rem_zero ? S_DIV_AG : S_ZERO;
                end
            end
            S_DIV_AG:
            begin
                cmd.op = OP_DIV_AG;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_DIV_BG;
                end
            end
            S_DIV_BG:
            begin
                cmd.op = OP_DIV_BG;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_MUL_X;
                end
            end
            S_MUL_X:
            begin
                cmd.op = OP_MUL_X;
                state_next = S_NEG_X;
            end
            S_NEG_X:
            begin
                cmd.op = OP_NEG_X;
                state_next = S_DIV_X;
            end
            S_DIV_X:
            begin
                cmd.op = OP_DIV_X;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_MUL_Y;
                end
            end
            S_MUL_Y:
            begin
                cmd.op = OP_MUL_Y;
                state_next = S_DIV_Y;
            end
            S_DIV_Y:
            begin
                cmd.op = OP_DIV_Y;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_T1L;
                end
            end
            S_T1L:
            begin
                cmd.op = OP_DIV_T1L;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_T1H;
                end
            end
            S_T1H:
            begin
                cmd.op = OP_DIV_T1H;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_T2L;
                end
            end
            S_T2L:
            begin
                cmd.op = OP_DIV_T2L;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_T2H;
                end
            end
            S_T2H:
            begin
                cmd.op = OP_DIV_T2H;
                is_div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_FIN_GEN;
                end
            end
            S_FIN_GEN:
            begin
                cmd.op = OP_FIN_GEN;
                state_next = S_OUT;
            end
            S_ZERO:
            begin
                cmd.op = OP_ZERO;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // one start pulse per divide state, cleared when the result lands
        cmd.div_start = is_div && !started_reg;
        started_next  = is_div && !sts.div_done;
        out_valid_next = cmd.push | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== sv/diophantine_range_counter_top.sv =====
// ----------------------------------------------------------------------------
// diophantine_range_counter_top
// counts integer solutions of a*x + b*y = c inside an x range and a y range
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+-----------------------------------
//  in      | in_valid / in_stall         | coef_a coef_b rhs_c x_low x_high
//          |                             | y_low y_high
//  out     | out_valid / out_stall       | solution_count
//
//  one item at a time; every division uses one radix-2 divider. the general
//  case runs the euclid steps and then nine divisions before out_valid rises;
//  when the gcd does not divide c it stops after the first of them with a
//  zero count. one zero coefficient takes a single division, and two zero
//  coefficients take none.
//  reset is asynchronous and clears the sequencer and output valid.
//  a held result stalls only the sequencer; the next input transfer can
//  follow in the cycle after the result is pushed.
// ----------------------------------------------------------------------------
module diophantine_range_counter_top
    import drc_pkg::*;
#(
    parameter int COEF_WIDTH = DEF_COEF_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [IN_W-1:0] coef_a,
    input  logic signed [IN_W-1:0] coef_b,
    input  logic signed [IN_W-1:0] rhs_c,
    input  logic signed [XYW-1:0]  x_low,
    input  logic signed [XYW-1:0]  x_high,
    input  logic signed [XYW-1:0]  y_low,
    input  logic signed [XYW-1:0]  y_high,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CNTW-1:0]        solution_count
);

    cmd_t cmd;
    sts_t sts;

    drc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    drc_dp #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .coef_a         (coef_a),
        .coef_b         (coef_b),
        .rhs_c          (rhs_c),
        .x_low          (x_low),
        .x_high         (x_high),
        .y_low          (y_low),
        .y_high         (y_high),
        .solution_count (solution_count)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in flight");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in flight");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !in_stall)
        else $error("operand load outside idle");
`endif

endmodule
